FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold while out of reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: never");

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: src/ect_pkg.sv
// ----------------------------------------------------------------------------
// ect_pkg
// Types and codes for the ear-clipping triangulator.
// ----------------------------------------------------------------------------
package ect_pkg;

  localparam int CORNER_W = 5;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_TRI    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_TRI = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD    = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RES_WAIT,
    S_SH_INIT,
    S_SH_LDP,
    S_SH_LDQ,
    S_SH_ACC,
    S_IDX,
    S_CL_TOP,
    S_CL_UVW,
    S_CL_RA,
    S_CL_RB,
    S_CL_RC,
    S_CL_PA,
    S_CL_PB,
    S_CL_PC,
    S_CL_CONV,
    S_CL_PCHK,
    S_CL_PI,
    S_CL_PP,
    S_CL_T1,
    S_CL_T2,
    S_CL_T3,
    S_CL_STORE,
    S_CL_SH,
    S_CL_SHW,
    S_EM_RD,
    S_EM_OUT,
    S_EM_WAIT,
    S_MUL1,
    S_MUL2,
    S_DIFF
  } state_t;

endpackage

FILE: src/ear_clipping_triangulator_unit.sv
// ----------------------------------------------------------------------------
// ear_clipping_triangulator_unit
// Ear-clipping triangulation of a simple polygon with exact integer math.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one vertex per transaction;
//   last_vertex marks the final vertex. After a non-final vertex the unit
//   stays ready. The final vertex starts the solve; in_ready stays low until
//   every result of the polygon has been taken on the output channel.
//   Output channel (out_valid/out_ready) carries either the buffered
//   triangles (status 0, last_result on the final one) or a single status
//   result (no triangles, or bad polygon).
//   All geometry goes through one shared orientation unit: a signed
//   multiplier used twice and a subtract. Shoelace: one orientation test per
//   vertex. Each ear candidate costs a convexity test plus up to three
//   orientation tests per other remaining vertex, and each clip a list shift
//   over the entries after it, so the solve is cubic in the vertex count
//   worst case. Each triangle is then sent as its own result.
//   A stalled receiver holds the result register; nothing is lost.
//   Reset (rst, synchronous) clears the vertex count, the overflow flag and
//   the output valid; the stores need no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ear_clipping_triangulator_unit #(
  parameter int MAX_VERTICES = 32,
  parameter int COORD_WIDTH  = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  vertex_x,
  input  logic signed [31:0]  vertex_y,
  input  logic                last_vertex,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ect_pkg::CORNER_W-1:0] corner_a,
  output logic [ect_pkg::CORNER_W-1:0] corner_b,
  output logic [ect_pkg::CORNER_W-1:0] corner_c,
  output logic [ect_pkg::STATUS_W-1:0] status,
  output logic                last_result
);

  localparam int IW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int RCW  = CNTW + 1;
  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * CW + 2;
  localparam int XW   = PW + 1;
  localparam int AW   = XW + IW + 1;

  // storage
  logic signed [CW-1:0] x_mem [MAX_VERTICES];
  logic signed [CW-1:0] y_mem [MAX_VERTICES];
  logic [IW-1:0]        idx_mem [MAX_VERTICES];
  logic [3*IW-1:0]      tri_mem [MAX_VERTICES];

  logic signed [CW-1:0] rd_x, rd_y;
  logic [IW-1:0]        idx_rd;
  logic [3*IW-1:0]      tri_rd;
  logic [IW-1:0]        pt_addr, idx_raddr;

  ect_pkg::state_t state, state_next, ret;

  logic [CNTW-1:0] vcnt, n, nv, q, p, sh, ntri, k;
  logic            ovf;
  logic [RCW-1:0]  rcount;
  logic [IW-1:0]   u, v, w, ia, ib, ic;
  logic signed [CW-1:0] ox, oy, sx, sy, tx, ty, ax, ay, bx, by, cx, cy, qx, qy;
  logic signed [PW-1:0] prod1, prod2;
  logic signed [XW-1:0] crs;
  logic signed [AW-1:0] acc;

  logic signed [DW-1:0] dx1, dy1, dx2, dy2;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic [IW-1:0] u_c, w_c;
  logic in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign in_ready = (state == ect_pkg::S_IDLE);

  assign dx1 = DW'(sx) - DW'(ox);
  assign dy1 = DW'(sy) - DW'(oy);
  assign dx2 = DW'(tx) - DW'(ox);
  assign dy2 = DW'(ty) - DW'(oy);

  // one multiplier, operands picked by the step
  assign mul_a = (state == ect_pkg::S_MUL1) ? dx1 : dy1;
  assign mul_b = (state == ect_pkg::S_MUL1) ? dy2 : dx2;
  assign prod  = PW'(mul_a) * PW'(mul_b);

  assign u_c = (v == '0) ? IW'(nv - 1'b1) : v - 1'b1;
  assign w_c = (CNTW'(v) + 1'b1 == nv) ? '0 : v + 1'b1;

  // memories
  always_ff @(posedge clk) begin
    if (in_acc && vcnt < CNTW'(MAX_VERTICES)) begin
      x_mem[IW'(vcnt)] <= vertex_x[CW-1:0];
      y_mem[IW'(vcnt)] <= vertex_y[CW-1:0];
    end
    rd_x   <= x_mem[pt_addr];
    rd_y   <= y_mem[pt_addr];
    idx_rd <= idx_mem[idx_raddr];
    tri_rd <= tri_mem[IW'(k)];
    if (state == ect_pkg::S_IDX) begin
      idx_mem[IW'(q)] <= (acc > 0) ? IW'(q) : IW'(n - 1'b1 - q);
    end else if (state == ect_pkg::S_CL_SHW) begin
      idx_mem[IW'(sh)] <= idx_rd;
    end
    if (state == ect_pkg::S_CL_STORE) begin
      tri_mem[IW'(ntri)] <= {ia, ib, ic};
    end
  end

  // read address select
  always_comb begin
    pt_addr   = '0;
    idx_raddr = '0;
    unique case (state)
      ect_pkg::S_SH_INIT: pt_addr = IW'(n - 1'b1);
      ect_pkg::S_SH_LDP:  pt_addr = IW'(q);
      ect_pkg::S_SH_ACC:  pt_addr = IW'(q + 1'b1);
      ect_pkg::S_CL_UVW:  idx_raddr = u_c;
      ect_pkg::S_CL_RA:   idx_raddr = v;
      ect_pkg::S_CL_RB:   idx_raddr = w;
      ect_pkg::S_CL_RC:   pt_addr = ia;
      ect_pkg::S_CL_PA:   pt_addr = ib;
      ect_pkg::S_CL_PB:   pt_addr = ic;
      ect_pkg::S_CL_PCHK: idx_raddr = IW'(p);
      ect_pkg::S_CL_PI:   pt_addr = idx_rd;
      ect_pkg::S_CL_SH:   idx_raddr = IW'(sh + 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ect_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ect_pkg::S_IDLE: begin
        if (in_acc && last_vertex) begin
          if (ovf || vcnt >= CNTW'(MAX_VERTICES) && !(vcnt < CNTW'(MAX_VERTICES)))
            state_next = (ovf || vcnt == CNTW'(MAX_VERTICES)) ?
                         ect_pkg::S_RES_WAIT : ect_pkg::S_SH_INIT;
          else if (vcnt + 1'b1 < CNTW'(3)) state_next = ect_pkg::S_RES_WAIT;
          else state_next = ect_pkg::S_SH_INIT;
        end
      end
      ect_pkg::S_RES_WAIT: if (out_acc) state_next = ect_pkg::S_IDLE;
      ect_pkg::S_SH_INIT:  state_next = ect_pkg::S_SH_LDP;
      ect_pkg::S_SH_LDP:   state_next = ect_pkg::S_SH_LDQ;
      ect_pkg::S_SH_LDQ:   state_next = ect_pkg::S_MUL1;
      ect_pkg::S_SH_ACC:
        state_next = (q + 1'b1 == n) ? ect_pkg::S_IDX : ect_pkg::S_SH_LDQ;
      ect_pkg::S_IDX:
        state_next = (q + 1'b1 == n) ? ect_pkg::S_CL_TOP : ect_pkg::S_IDX;
      ect_pkg::S_CL_TOP: begin
        if (nv <= CNTW'(2)) state_next = ect_pkg::S_EM_RD;
        else if (rcount == '0) state_next = ect_pkg::S_RES_WAIT;
        else state_next = ect_pkg::S_CL_UVW;
      end
      ect_pkg::S_CL_UVW:  state_next = ect_pkg::S_CL_RA;
      ect_pkg::S_CL_RA:   state_next = ect_pkg::S_CL_RB;
      ect_pkg::S_CL_RB:   state_next = ect_pkg::S_CL_RC;
      ect_pkg::S_CL_RC:   state_next = ect_pkg::S_CL_PA;
      ect_pkg::S_CL_PA:   state_next = ect_pkg::S_CL_PB;
      ect_pkg::S_CL_PB:   state_next = ect_pkg::S_CL_PC;
      ect_pkg::S_CL_PC:   state_next = ect_pkg::S_MUL1;
      ect_pkg::S_CL_CONV:
        state_next = crs[XW-1] ? ect_pkg::S_CL_TOP : ect_pkg::S_CL_PCHK;
      ect_pkg::S_CL_PCHK: begin
        if (p == nv) state_next = ect_pkg::S_CL_STORE;
        else if (IW'(p) == u || IW'(p) == v || IW'(p) == w)
          state_next = ect_pkg::S_CL_PCHK;
        else state_next = ect_pkg::S_CL_PI;
      end
      ect_pkg::S_CL_PI:   state_next = ect_pkg::S_CL_PP;
      ect_pkg::S_CL_PP:   state_next = ect_pkg::S_MUL1;
      ect_pkg::S_CL_T1, ect_pkg::S_CL_T2:
        state_next = crs[XW-1] ? ect_pkg::S_CL_PCHK : ect_pkg::S_MUL1;
      ect_pkg::S_CL_T3:
        state_next = crs[XW-1] ? ect_pkg::S_CL_PCHK : ect_pkg::S_CL_TOP;
      ect_pkg::S_CL_STORE: state_next = ect_pkg::S_CL_SH;
      ect_pkg::S_CL_SH:
        state_next = (sh + 1'b1 >= nv) ? ect_pkg::S_CL_TOP : ect_pkg::S_CL_SHW;
      ect_pkg::S_CL_SHW:  state_next = ect_pkg::S_CL_SH;
      ect_pkg::S_EM_RD:   state_next = ect_pkg::S_EM_OUT;
      ect_pkg::S_EM_OUT:  state_next = ect_pkg::S_EM_WAIT;
      ect_pkg::S_EM_WAIT:
        if (out_acc) state_next = last_result ? ect_pkg::S_IDLE : ect_pkg::S_EM_RD;
      ect_pkg::S_MUL1:    state_next = ect_pkg::S_MUL2;
      ect_pkg::S_MUL2:    state_next = ect_pkg::S_DIFF;
      ect_pkg::S_DIFF:    state_next = ret;
      default:            state_next = ect_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vcnt      <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_acc) out_valid <= 1'b0;
      unique case (state)
        ect_pkg::S_IDLE: begin
          if (in_acc) begin
            if (vcnt < CNTW'(MAX_VERTICES)) vcnt <= vcnt + 1'b1;
            else ovf <= 1'b1;
            if (last_vertex) begin
              vcnt <= '0;
              ovf  <= 1'b0;
              n    <= (vcnt < CNTW'(MAX_VERTICES)) ? vcnt + 1'b1 : vcnt;
              q    <= '0;
              acc  <= '0;
              corner_a <= '0;
              corner_b <= '0;
              corner_c <= '0;
              last_result <= 1'b1;
              if (ovf || vcnt == CNTW'(MAX_VERTICES)) begin
                status    <= ect_pkg::ST_BAD;
                out_valid <= 1'b1;
              end else if (vcnt + 1'b1 < CNTW'(3)) begin
                status    <= ect_pkg::ST_NO_TRI;
                out_valid <= 1'b1;
              end
            end
          end
        end
        ect_pkg::S_SH_LDP: begin
          sx <= rd_x;
          sy <= rd_y;
        end
        ect_pkg::S_SH_LDQ: begin
          tx <= rd_x;
          ty <= rd_y;
          ox <= '0;
          oy <= '0;
          ret <= ect_pkg::S_SH_ACC;
        end
        ect_pkg::S_SH_ACC: begin
          acc <= acc + AW'(crs);
          sx <= tx;
          sy <= ty;
          q  <= (q + 1'b1 == n) ? '0 : q + 1'b1;
        end
        ect_pkg::S_IDX: begin
          q <= q + 1'b1;
          v      <= IW'(n - 1'b1);
          nv     <= n;
          rcount <= RCW'(n) << 1;
          ntri   <= '0;
        end
        ect_pkg::S_CL_TOP: begin
          if (nv <= CNTW'(2)) begin
            k <= '0;
          end else if (rcount == '0) begin
            status      <= ect_pkg::ST_BAD;
            last_result <= 1'b1;
            corner_a    <= '0;
            corner_b    <= '0;
            corner_c    <= '0;
            out_valid   <= 1'b1;
          end else begin
            rcount <= rcount - 1'b1;
            // v may sit one past the end after clipping the last entry
            if (CNTW'(v) + 1'b1 == nv) v <= '0;
            else if (CNTW'(v) == nv) v <= IW'(1);
            else v <= v + 1'b1;
          end
        end
        ect_pkg::S_CL_UVW: begin
          u <= u_c;
          w <= w_c;
        end
        ect_pkg::S_CL_RA: ia <= idx_rd;
        ect_pkg::S_CL_RB: ib <= idx_rd;
        ect_pkg::S_CL_RC: ic <= idx_rd;
        ect_pkg::S_CL_PA: begin
          ax <= rd_x;
          ay <= rd_y;
        end
        ect_pkg::S_CL_PB: begin
          bx <= rd_x;
          by <= rd_y;
        end
        ect_pkg::S_CL_PC: begin
          cx <= rd_x;
          cy <= rd_y;
          ox <= ax;
          oy <= ay;
          sx <= bx;
          sy <= by;
          tx <= rd_x;
          ty <= rd_y;
          ret <= ect_pkg::S_CL_CONV;
        end
        ect_pkg::S_CL_CONV: p <= '0;
        ect_pkg::S_CL_PCHK: begin
          if (p != nv && (IW'(p) == u || IW'(p) == v || IW'(p) == w))
            p <= p + 1'b1;
        end
        ect_pkg::S_CL_PP: begin
          qx <= rd_x;
          qy <= rd_y;
          // edge b -> c
          ox <= bx;
          oy <= by;
          sx <= cx;
          sy <= cy;
          tx <= rd_x;
          ty <= rd_y;
          ret <= ect_pkg::S_CL_T1;
        end
        ect_pkg::S_CL_T1: begin
          if (crs[XW-1]) p <= p + 1'b1;
          // edge c -> a
          ox <= cx;
          oy <= cy;
          sx <= ax;
          sy <= ay;
          tx <= qx;
          ty <= qy;
          ret <= ect_pkg::S_CL_T2;
        end
        ect_pkg::S_CL_T2: begin
          if (crs[XW-1]) p <= p + 1'b1;
          // edge a -> b
          ox <= ax;
          oy <= ay;
          sx <= bx;
          sy <= by;
          tx <= qx;
          ty <= qy;
          ret <= ect_pkg::S_CL_T3;
        end
        ect_pkg::S_CL_T3: if (crs[XW-1]) p <= p + 1'b1;
        ect_pkg::S_CL_STORE: begin
          ntri <= ntri + 1'b1;
          sh   <= CNTW'(v);
        end
        ect_pkg::S_CL_SH: begin
          if (sh + 1'b1 >= nv) begin
            nv     <= nv - 1'b1;
            rcount <= RCW'(nv - 1'b1) << 1;
          end
        end
        ect_pkg::S_CL_SHW: sh <= sh + 1'b1;
        ect_pkg::S_EM_OUT: begin
          corner_a    <= ect_pkg::CORNER_W'(tri_rd[3*IW-1:2*IW]);
          corner_b    <= ect_pkg::CORNER_W'(tri_rd[2*IW-1:IW]);
          corner_c    <= ect_pkg::CORNER_W'(tri_rd[IW-1:0]);
          status      <= ect_pkg::ST_TRI;
          last_result <= (k + 1'b1 == ntri);
          out_valid   <= 1'b1;
        end
        ect_pkg::S_EM_WAIT: if (out_acc) k <= k + 1'b1;
        ect_pkg::S_MUL1: prod1 <= prod;
        ect_pkg::S_MUL2: prod2 <= prod;
        ect_pkg::S_DIFF: crs <= XW'(prod1) - XW'(prod2);
        default: ;
      endcase
    end
  end

  `ASSERT_NEVER(a_ready_while_result, in_ready && out_valid)
  `ASSERT_IMPL(a_status_single, out_valid && status != ect_pkg::ST_TRI,
               last_result && corner_a == '0 && corner_b == '0 && corner_c == '0)
  `ASSERT_NEXT(a_last_to_idle, out_valid && out_ready && last_result,
               state == ect_pkg::S_IDLE)
  `ASSERT_NEVER(a_count_range, vcnt > CNTW'(MAX_VERTICES))

endmodule
